// ----- src/wsr_pkg.sv -----
// Package for the wNAF scalar recoder: constants, queue item and result types.
package wsr_pkg;

    localparam int SCALAR_BITS_DEF = 128;
    localparam int MAG_MAX         = 128;
    localparam int CFG_W           = 5;
    localparam int DIGIT_W         = 16;
    localparam int CNT_W           = 8;
    localparam int QUEUE_DEPTH     = 2;
    localparam int RES_DEPTH       = 2;

    localparam logic [CFG_W-1:0] W_MIN   = 5'd3;
    localparam logic [CFG_W-1:0] W_MAX   = 5'd16;
    localparam logic [CFG_W-1:0] W_RESET = 5'd5;

    typedef struct packed {
        logic [MAG_MAX-1:0] mag;
        logic               neg;
        logic               zero;
    } t_item;

    typedef struct packed {
        logic signed [DIGIT_W-1:0] digit;
        logic [CNT_W-1:0]          zeros_before;
        logic [CNT_W-1:0]          position;
        logic                      last;
        logic                      empty_res;
    } t_result;

    typedef enum logic [0:0] {
        BK_IDLE,
        BK_RUN
    } t_back_state;

endpackage

// ----- src/wsr_fifo.sv -----
// Small synchronous FIFO with full/empty flags.
module wsr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PtrW-1:0]  r_wr_ptr;
    logic [PtrW-1:0]  r_rd_ptr;
    logic [CntW-1:0]  r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CntW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- src/wsr_front.sv -----
// Front stage: accepts scalars, trims to the scalar width and flags zero.
module wsr_front import wsr_pkg::*; #(
    parameter int SCALAR_BITS = SCALAR_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [63:0] i_magnitude_low,
    input  logic [63:0] i_magnitude_high,
    input  logic        i_negative,
    output logic        o_q_push,
    output t_item       o_q_item,
    input  logic        i_q_full
);

    localparam logic [MAG_MAX-1:0] MagMask = {MAG_MAX{1'b1}} >> (MAG_MAX - SCALAR_BITS);

    logic               r_valid;
    t_item              r_item;
    logic [MAG_MAX-1:0] mag;
    logic               advance;

    assign mag      = {i_magnitude_high, i_magnitude_low} & MagMask;
    assign advance  = !r_valid || !i_q_full;
    assign full     = !advance;
    assign o_q_push = r_valid;
    assign o_q_item = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (advance) begin
            r_valid <= push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && push) begin
            r_item.mag  <= mag;
            r_item.neg  <= i_negative;
            r_item.zero <= (mag == '0);
        end
    end

endmodule

// ----- src/wsr_back.sv -----
// Back stage: emits nonzero digits, one position a cycle unless stalled.
module wsr_back import wsr_pkg::*; #(
    parameter int SCALAR_BITS = SCALAR_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [CFG_W-1:0] i_window,
    input  logic             i_q_empty,
    input  t_item            i_q_item,
    output logic             o_q_pop,
    output logic             o_res_push,
    output t_result          o_res,
    input  logic             i_res_full
);

    localparam int XW   = SCALAR_BITS + 1;
    localparam int PosW = $clog2(SCALAR_BITS + 2);

    t_back_state        r_state;
    t_back_state        n_state;
    logic [XW-1:0]      r_x;
    logic [XW-1:0]      n_x;
    logic               r_neg;
    logic [PosW-1:0]    r_pos;
    logic [PosW-1:0]    n_pos;
    logic [PosW-1:0]    r_next_free;
    logic [PosW-1:0]    n_next_free;

    logic [CFG_W-1:0]   w;
    logic [XW-1:0]      low_mask;
    logic [DIGIT_W-1:0] word;
    logic               half_set;
    logic [XW-1:0]      x_dig;
    logic [XW-1:0]      x_step;
    logic [DIGIT_W:0]   d_wide;
    logic [DIGIT_W-1:0] d_mag;
    logic [PosW-1:0]    zeros;

    always_comb begin
        if (i_window < W_MIN) begin
            w = W_MIN;
        end else if (i_window > W_MAX) begin
            w = W_MAX;
        end else begin
            w = i_window;
        end
    end

    assign low_mask = (XW'(1) << w) - XW'(1);
    assign word     = r_x[DIGIT_W-1:0] & low_mask[DIGIT_W-1:0];
    assign half_set = |(word & (DIGIT_W'(1) << (w - 5'd1)));
    assign x_dig    = half_set ? ((r_x & ~low_mask) + (XW'(1) << w)) : (r_x & ~low_mask);
    assign x_step   = r_x[0] ? x_dig : r_x;
    assign d_wide   = {1'b0, word} - (half_set ? ((DIGIT_W + 1)'(1) << w) : '0);
    assign d_mag    = d_wide[DIGIT_W-1:0];
    assign zeros    = r_pos - r_next_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x         <= n_x;
        r_pos       <= n_pos;
        r_next_free <= n_next_free;
        if (r_state == BK_IDLE && !i_q_empty && !i_q_item.zero) begin
            r_neg <= i_q_item.neg;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_x         = r_x;
        n_pos       = r_pos;
        n_next_free = r_next_free;
        o_q_pop     = 1'b0;
        o_res_push  = 1'b0;
        o_res       = '0;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_q_empty) begin
                    if (i_q_item.zero) begin
                        o_res.empty_res = 1'b1;
                        if (!i_res_full) begin
                            o_res_push = 1'b1;
                            o_q_pop    = 1'b1;
                        end
                    end else begin
                        o_q_pop     = 1'b1;
                        n_x         = XW'(i_q_item.mag[SCALAR_BITS-1:0]);
                        n_pos       = '0;
                        n_next_free = '0;
                        n_state     = BK_RUN;
                    end
                end
            end
            BK_RUN: begin
                o_res.digit        = r_neg ? -d_mag : d_mag;
                o_res.zeros_before = CNT_W'(zeros);
                o_res.position     = CNT_W'(r_pos);
                o_res.last         = (x_step == '0);
                if (!(r_x[0] && i_res_full)) begin
                    o_res_push = r_x[0];
                    n_x        = x_step >> 1;
                    n_pos      = r_pos + 1'b1;
                    if (r_x[0]) begin
                        n_next_free = r_pos + 1'b1;
                    end
                    if (x_step == '0) begin
                        n_state = BK_IDLE;
                    end
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

endmodule

// ----- src/wnaf_scalar_recoder.sv -----
// Top level of the width-w NAF scalar recoder.
//
// Input channel: a scalar magnitude (two 64-bit halves) plus sign is taken on
// a rising edge with push high and full low. Result channel: while empty is
// low, the oldest digit record sits on the o_ ports; pop takes it.
// One transaction per nonzero digit, lowest position first, the highest one
// carrying o_last; a zero scalar gives a single transaction with o_empty_res.
// The window width is written through i_cfg_we/i_cfg_window_width; the user must
// write it only while the block is idle; the block itself does not enforce this.
// Values below 3 act as 3, above 16 as 16; reset value is 5. A scalar passes
// the front register and the item queue; the back stage loads it, then walks
// one digit position per cycle up to the highest digit, pushing each nonzero
// digit into the result queue and holding while that queue is full; a zero
// scalar's record is pushed straight from idle.
// A two-entry queue between front and back and a two-entry result queue let
// new scalars be taken while results wait. When the receiver stalls, the back
// stage holds on the pending digit and full rises once the queues fill.
// Synchronous active-low reset empties all queues and returns to idle.
module wnaf_scalar_recoder import wsr_pkg::*; #(
    parameter int SCALAR_BITS = SCALAR_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic [63:0]               i_magnitude_low,
    input  logic [63:0]               i_magnitude_high,
    input  logic                      i_negative,
    output logic                      empty,
    input  logic                      pop,
    output logic signed [DIGIT_W-1:0] o_digit,
    output logic [CNT_W-1:0]          o_zeros_before,
    output logic [CNT_W-1:0]          o_position,
    output logic                      o_last,
    output logic                      o_empty_res,
    input  logic                      i_cfg_we,
    input  logic [CFG_W-1:0]          i_cfg_window_width
);

    logic [CFG_W-1:0] r_window;
    logic             q_push;
    t_item            q_in;
    logic             q_full;
    logic             q_pop;
    logic             q_empty;
    logic [$bits(t_item)-1:0] q_out_bits;
    t_item            q_out;
    logic             res_push;
    t_result          res_in;
    logic             res_full;
    logic [$bits(t_result)-1:0] res_out_bits;
    t_result          res_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= W_RESET;
        end else if (i_cfg_we) begin
            r_window <= i_cfg_window_width;
        end
    end

    wsr_front #(.SCALAR_BITS(SCALAR_BITS)) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_magnitude_low  (i_magnitude_low),
        .i_magnitude_high (i_magnitude_high),
        .i_negative       (i_negative),
        .o_q_push         (q_push),
        .o_q_item         (q_in),
        .i_q_full         (q_full)
    );

    wsr_fifo #(.WIDTH($bits(t_item)), .DEPTH(QUEUE_DEPTH)) u_item_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out_bits),
        .o_empty (q_empty)
    );

    assign q_out = t_item'(q_out_bits);

    wsr_back #(.SCALAR_BITS(SCALAR_BITS)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_window   (r_window),
        .i_q_empty  (q_empty),
        .i_q_item   (q_out),
        .o_q_pop    (q_pop),
        .o_res_push (res_push),
        .o_res      (res_in),
        .i_res_full (res_full)
    );

    wsr_fifo #(.WIDTH($bits(t_result)), .DEPTH(RES_DEPTH)) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_out_bits),
        .o_empty (empty)
    );

    assign res_out        = t_result'(res_out_bits);
    assign o_digit        = res_out.digit;
    assign o_zeros_before = res_out.zeros_before;
    assign o_position     = res_out.position;
    assign o_last         = res_out.last;
    assign o_empty_res    = res_out.empty_res;

endmodule

// ----- src/wsr_checker.sv -----
// Port-level checks for the wNAF scalar recoder, bound to the top level.
module wsr_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               empty,
    input logic signed [15:0] o_digit,
    input logic [7:0]         o_zeros_before,
    input logic [7:0]         o_position,
    input logic               o_last,
    input logic               o_empty_res
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_empty_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_empty_res) |-> (o_digit == 16'sd0 && !o_last && o_position == 8'd0))
        else $error("malformed empty-scalar record");

    a_odd_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_empty_res) |-> o_digit[0])
        else $error("digit is not odd");

    a_zero_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_zeros_before <= o_position && o_position <= 8'd128))
        else $error("zero run or position out of range");

endmodule

bind wnaf_scalar_recoder wsr_checker u_wsr_checker (.*);
